// ----- rtl/job_slot_table_tracker_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the job slot table tracker
// Shared implication forms used by the concurrent checks of the top level.
// ---------------------------------------------------------------------------
`ifndef JOB_SLOT_TABLE_TRACKER_UNIT_ASSERT_SVH
`define JOB_SLOT_TABLE_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define JST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define JST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jst_pkg.sv -----
// ---------------------------------------------------------------------------
// Job slot table tracker package
// Command codes, sequencer states, slot and result types, shared constants.
// ---------------------------------------------------------------------------
package jst_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DATA_W      = 16;

    localparam logic [DATA_W-1:0] SEQ_FIRST = 16'd1;
    localparam logic [DATA_W-1:0] SEQ_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_DONE   = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SWEEP  = 3'd4
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] id;
        logic              done;
        logic [DATA_W-1:0] status;
    } t_slot;

    // what the compare unit looks at for one slot
    typedef struct packed {
        t_cmd              cmd;
        logic              valid;
        t_slot             slot;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] lid;
    } t_probe;

    // one result item
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] key;
        logic              state;
        logic [DATA_W-1:0] status;
        logic              last;
    } t_res;

endpackage

// ----- rtl/jst_cmd_if.sv -----
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface jst_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] key;
    logic [15:0] lookup_id;
    logic [15:0] exit_status;

    modport source (output valid, command, key, lookup_id, exit_status, input ready);
    modport sink   (input valid, command, key, lookup_id, exit_status, output ready);
endinterface

// ----- rtl/jst_res_if.sv -----
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface jst_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [15:0] entry_id;
    logic [15:0] entry_key;
    logic        entry_state;
    logic [15:0] entry_status;
    logic        last;

    modport source (output valid, hit, entry_id, entry_key, entry_state, entry_status, last,
                    input ready);
    modport sink   (input valid, hit, entry_id, entry_key, entry_state, entry_status, last,
                    output ready);
endinterface

// ----- rtl/jst_match.sv -----
// ---------------------------------------------------------------------------
// Slot compare unit
// Decides whether one slot satisfies the search of the current command.
// ---------------------------------------------------------------------------
module jst_match (
    input  jst_pkg::t_probe i_probe,
    output logic            o_match
);
    import jst_pkg::*;

    // one compare per command; unused codes never match
    always_comb begin
        case (i_probe.cmd)
            CMD_ADD: begin
                o_match = !i_probe.valid;
            end
            CMD_DONE: begin
                o_match = i_probe.valid && !i_probe.slot.done &&
                          (i_probe.slot.key == i_probe.key);
            end
            CMD_FIND, CMD_REMOVE: begin
                o_match = i_probe.valid && (i_probe.slot.id == i_probe.lid);
            end
            CMD_SWEEP: begin
                o_match = i_probe.valid && i_probe.slot.done;
            end
            default: begin
                o_match = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/job_slot_table_tracker_unit.sv -----
// ---------------------------------------------------------------------------
// Job slot table tracker
// Table of task slots scanned one slot a cycle, while not stalled, through a shared compare unit.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        command, key, lookup_id, exit_status
//  o_res     out  valid/ready        hit, entry_id, entry_key, entry_state,
//                                    entry_status, last
//
//  For each command the sequencer reads one slot a cycle, unless stalled,
//  from the slot memory (registered read) and compares it in the cycle after.
//  Hits on add, mark done, find and remove end the scan early.
//  Sweep holds each done entry back until the next one is found, so last is
//  known.
//  Reset clears the valid bits at once; there is no clearing pass.
//  A full output register stalls the scan when a result is due; ready is high only when idle.
// ---------------------------------------------------------------------------
module job_slot_table_tracker_unit #(
    parameter int ENTRIES = jst_pkg::ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jst_cmd_if.sink    i_cmd,
    jst_res_if.source  o_res
);
    import jst_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0]    LAST_IDX = CW'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

    // sequencer and command registers
    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_key, r_lid, r_st;
    logic [DATA_W-1:0] r_next_id;

    // scan pipeline
    logic [CW-1:0]     r_rd_idx;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    t_slot             r_rdata;

    // table
    logic [ENTRIES-1:0] r_valid;
    t_slot              mem [ENTRIES];

    // sweep: entry held back until the next one is found
    logic              r_pnd_vld;
    logic [DATA_W-1:0] r_pnd_id, r_pnd_key, r_pnd_status;
    logic [CNT_W-1:0]  r_cnt;

    // output register
    logic              r_out_vld;
    t_res              r_out;

    // control
    t_probe            c_probe;
    logic              c_match, c_cmd_ok, c_end, c_hit, c_emit, c_done, c_go, c_out_free;
    t_res              c_res;
    logic              c_accept;

    assign c_accept   = i_cmd.valid && i_cmd.ready;
    assign c_out_free = !r_out_vld || o_res.ready;

    // shared compare unit
    always_comb begin
        c_probe.cmd   = r_cmd;
        c_probe.valid = r_valid[r_cmp_idx];
        c_probe.slot  = r_rdata;
        c_probe.key   = r_key;
        c_probe.lid   = r_lid;
    end

    jst_match u_match (
        .i_probe (c_probe),
        .o_match (c_match)
    );

    // sequencer outputs
    always_comb begin
        c_cmd_ok = (r_cmd == CMD_ADD) || (r_cmd == CMD_DONE) || (r_cmd == CMD_FIND) ||
                   (r_cmd == CMD_REMOVE) || (r_cmd == CMD_SWEEP);
        c_end    = !c_cmd_ok || ((r_cmd == CMD_SWEEP) && (r_cnt == CNT_MAX)) ||
                   (!r_cmp_vld && (r_rd_idx == LAST_IDX));
        c_hit    = (r_state == ST_SCAN) && !c_end && r_cmp_vld && c_match;
        c_emit   = 1'b0;
        c_done   = 1'b0;
        c_res    = '0;
        c_res.last = 1'b1;
        if (r_state == ST_SCAN) begin
            if (c_end) begin
                c_emit = 1'b1;
                c_done = 1'b1;
                if ((r_cmd == CMD_SWEEP) && r_pnd_vld) begin
                    c_res.hit    = 1'b1;
                    c_res.id     = r_pnd_id;
                    c_res.key    = r_pnd_key;
                    c_res.state  = 1'b1;
                    c_res.status = r_pnd_status;
                end
            end else if (c_hit) begin
                c_res.hit = 1'b1;
                case (r_cmd)
                    CMD_ADD: begin
                        c_emit    = 1'b1;
                        c_done    = 1'b1;
                        c_res.id  = r_next_id;
                        c_res.key = r_key;
                    end
                    CMD_DONE: begin
                        c_emit       = 1'b1;
                        c_done       = 1'b1;
                        c_res.id     = r_rdata.id;
                        c_res.key    = r_rdata.key;
                        c_res.state  = 1'b1;
                        c_res.status = r_st;
                    end
                    CMD_SWEEP: begin
                        // release the held entry, it is not the final one
                        c_emit       = r_pnd_vld;
                        c_res.id     = r_pnd_id;
                        c_res.key    = r_pnd_key;
                        c_res.state  = 1'b1;
                        c_res.status = r_pnd_status;
                        c_res.last   = 1'b0;
                    end
                    default: begin
                        c_emit       = 1'b1;
                        c_done       = 1'b1;
                        c_res.id     = r_rdata.id;
                        c_res.key    = r_rdata.key;
                        c_res.state  = r_rdata.done;
                        c_res.status = r_rdata.status;
                    end
                endcase
            end
        end
        c_go = (r_state == ST_SCAN) && !(c_emit && !c_out_free);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (c_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (c_go && c_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_cmd.ready = (r_state == ST_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_next_id <= SEQ_FIRST;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_pnd_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (c_accept) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_pnd_vld <= 1'b0;
                r_cnt     <= '0;
            end else if (c_go) begin
                r_cmp_vld <= (r_rd_idx != LAST_IDX);
                if (r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
            end
            if (c_go && c_hit) begin
                case (r_cmd)
                    CMD_ADD: begin
                        r_valid[r_cmp_idx] <= 1'b1;
                        r_next_id <= (r_next_id == SEQ_MAX) ? SEQ_FIRST
                                                            : r_next_id + DATA_W'(1);
                    end
                    CMD_REMOVE: begin
                        r_valid[r_cmp_idx] <= 1'b0;
                    end
                    CMD_SWEEP: begin
                        r_valid[r_cmp_idx] <= 1'b0;
                        r_pnd_vld <= 1'b1;
                        r_cnt     <= r_cnt + CNT_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            if (c_go && c_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_cmd <= t_cmd'(i_cmd.command);
            r_key <= i_cmd.key;
            r_lid <= i_cmd.lookup_id;
            r_st  <= i_cmd.exit_status;
        end
        if (c_go) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (c_go && c_hit && (r_cmd == CMD_SWEEP)) begin
            r_pnd_id     <= r_rdata.id;
            r_pnd_key    <= r_rdata.key;
            r_pnd_status <= r_rdata.status;
        end
        if (c_go && c_emit) begin
            r_out <= c_res;
        end
    end

    // slot memory: one registered read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (c_go && (r_rd_idx != LAST_IDX)) begin
            r_rdata <= mem[r_rd_idx[IW-1:0]];
        end
        if (c_go && c_hit && (r_cmd == CMD_ADD)) begin
            mem[r_cmp_idx] <= '{key: r_key, id: r_next_id, done: 1'b0, status: '0};
        end else if (c_go && c_hit && (r_cmd == CMD_DONE)) begin
            mem[r_cmp_idx] <= '{key: r_rdata.key, id: r_rdata.id, done: 1'b1, status: r_st};
        end
    end

    // result port
    assign o_res.valid        = r_out_vld;
    assign o_res.hit          = r_out.hit;
    assign o_res.entry_id     = r_out.id;
    assign o_res.entry_key    = r_out.key;
    assign o_res.entry_state  = r_out.state;
    assign o_res.entry_status = r_out.status;
    assign o_res.last         = r_out.last;

    // checks
`include "job_slot_table_tracker_unit_assert.svh"

    `JST_ASSERT_NOW(a_miss_is_last, i_clk, i_rst_n, o_res.valid && !o_res.hit, o_res.last && (o_res.entry_id == '0), "miss result not final or not blank")
    `JST_ASSERT_NOW(a_more_keeps_scan, i_clk, i_rst_n, o_res.valid && !o_res.last, r_state == ST_SCAN, "non-final result with sequencer idle")
    `JST_ASSERT_NEXT(a_add_steps_id, i_clk, i_rst_n, c_go && c_hit && (r_cmd == CMD_ADD), (r_next_id != $past(r_next_id)) && (r_next_id != '0), "sequence id not advanced")

endmodule

// ----- tb/job_slot_table_tracker_unit_tb.sv -----
// ---------------------------------------------------------------------------
// Job slot table tracker testbench
// Drives add, mark-done, find, remove, sweep and unused commands through the
// command channel and checks every result item against a behavioural copy of
// the slot table. Covers empty and full tables, duplicate keys, a sweep of a
// completely done table under a long result hold-off, and a random mix with
// bursts of idling on both sides.
// ---------------------------------------------------------------------------
module job_slot_table_tracker_unit_tb;

    import jst_pkg::*;

    localparam int          ENTRIES        = ENTRIES_DEF;
    localparam logic [2:0]  CMD_RSVD_LO    = 3'd5;
    localparam logic [2:0]  CMD_RSVD_HI    = 3'd7;
    localparam logic [15:0] DUP_KEY        = 16'h00A5;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TAIL_CYCLES    = 2 * ENTRIES + 8;

    logic i_clk;
    logic i_rst_n;

    jst_cmd_if cmd_if ();
    jst_res_if res_if ();

    job_slot_table_tracker_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // behavioural copy of the slot table
    logic        tbl_valid  [ENTRIES];
    logic [15:0] tbl_key    [ENTRIES];
    logic [15:0] tbl_id     [ENTRIES];
    logic        tbl_done   [ENTRIES];
    logic [15:0] tbl_status [ENTRIES];
    logic [15:0] seq_next;

    // results still owed by the block, oldest first
    t_res        pending_reports [$];

    bit          cmd_idling;
    bit          res_idling;
    bit          res_hold_req;
    int          quiet_cycles;
    int          errors;
    int          n_cmds;
    int          n_reports;
    int          n_full;
    int          n_swept;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] rand_word();
        return 16'($urandom);
    endfunction

    function automatic void reset_tracker();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_key[i]    = '0;
            tbl_id[i]     = '0;
            tbl_done[i]   = 1'b0;
            tbl_status[i] = '0;
        end
        seq_next = SEQ_FIRST;
    endfunction

    // a slot below zero gives a miss item with every field but last zero
    function automatic t_res entry_report(input int slot, input logic is_last);
        t_res rpt;
        rpt = '0;
        if (slot >= 0) begin
            rpt.hit    = 1'b1;
            rpt.id     = tbl_id[slot];
            rpt.key    = tbl_key[slot];
            rpt.state  = tbl_done[slot];
            rpt.status = tbl_status[slot];
        end
        rpt.last = is_last;
        return rpt;
    endfunction

    function automatic int slot_of_id(input logic [15:0] lid);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_id[i] == lid) return i;
        return -1;
    endfunction

    // apply one accepted command and queue the result items it owes
    function automatic void track_command(input logic [2:0] cmd, input logic [15:0] key,
                                          input logic [15:0] lid, input logic [15:0] st);
        int slot;
        int swept [$];
        slot = -1;
        case (cmd)
            CMD_ADD: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!tbl_valid[i] && slot < 0) slot = i;
                if (slot >= 0) begin
                    tbl_key[slot]    = key;
                    tbl_id[slot]     = seq_next;
                    tbl_done[slot]   = 1'b0;
                    tbl_status[slot] = '0;
                    tbl_valid[slot]  = 1'b1;
                    if (seq_next == SEQ_MAX) begin
                        seq_next = SEQ_FIRST;
                    end else begin
                        seq_next = seq_next + 16'd1;
                    end
                end else begin
                    n_full++;
                end
                pending_reports.push_back(entry_report(slot, 1'b1));
            end
            CMD_DONE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && tbl_valid[i] && !tbl_done[i] && tbl_key[i] == key)
                        slot = i;
                if (slot >= 0) begin
                    tbl_done[slot]   = 1'b1;
                    tbl_status[slot] = st;
                end
                pending_reports.push_back(entry_report(slot, 1'b1));
            end
            CMD_FIND: begin
                pending_reports.push_back(entry_report(slot_of_id(lid), 1'b1));
            end
            CMD_REMOVE: begin
                slot = slot_of_id(lid);
                pending_reports.push_back(entry_report(slot, 1'b1));
                if (slot >= 0) tbl_valid[slot] = 1'b0;
            end
            CMD_SWEEP: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_done[i] && swept.size() < MAX_RESULTS)
                        swept.push_back(i);
                if (swept.size() == 0)
                    pending_reports.push_back(entry_report(-1, 1'b1));
                for (int n = 0; n < swept.size(); n++) begin
                    pending_reports.push_back(entry_report(swept[n], n == swept.size() - 1));
                    tbl_valid[swept[n]] = 1'b0;
                    n_swept++;
                end
            end
            default: begin
                pending_reports.push_back(entry_report(-1, 1'b1));
            end
        endcase
    endfunction

    function automatic logic [15:0] live_running_key();
        int cand [$];
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && !tbl_done[i]) cand.push_back(i);
        if (cand.size() == 0) return rand_word();
        return tbl_key[cand[$urandom_range(0, cand.size() - 1)]];
    endfunction

    function automatic logic [15:0] live_id();
        int cand [$];
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i]) cand.push_back(i);
        if (cand.size() == 0) return rand_word();
        return tbl_id[cand[$urandom_range(0, cand.size() - 1)]];
    endfunction

    // offer one command item and wait until it is accepted
    task automatic issue_cmd(input logic [2:0] cmd, input logic [15:0] key,
                             input logic [15:0] lid, input logic [15:0] st);
        if (cmd_idling && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= cmd;
        cmd_if.key         <= key;
        cmd_if.lookup_id   <= lid;
        cmd_if.exit_status <= st;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        track_command(cmd, key, lid, st);
        n_cmds++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : res_ready_drive
        forever begin
            @(posedge i_clk);
            if (res_hold_req) begin
                res_hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (res_idling && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    // compare each accepted result item with the oldest one owed
    always @(posedge i_clk) begin : report_check
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_reports++;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got hit %b id %h key %h",
                         $time, res_if.hit, res_if.entry_id, res_if.entry_key);
            end else begin
                want = pending_reports.pop_front();
                check_field("hit", 16'(want.hit), 16'(res_if.hit));
                check_field("entry_id", want.id, res_if.entry_id);
                check_field("entry_key", want.key, res_if.entry_key);
                check_field("entry_state", 16'(want.state), 16'(res_if.entry_state));
                check_field("entry_status", want.status, res_if.entry_status);
                check_field("last", 16'(want.last), 16'(res_if.last));
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin : watchdog
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results still owed",
                     $time, quiet_cycles, pending_reports.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // misses on an empty table and the unused command codes
    task automatic test_empty_misses();
        issue_cmd(CMD_SWEEP, rand_word(), rand_word(), rand_word());
        issue_cmd(CMD_FIND, rand_word(), 16'h0000, rand_word());
        issue_cmd(CMD_REMOVE, rand_word(), 16'hFFFF, rand_word());
        issue_cmd(CMD_DONE, 16'h0000, rand_word(), 16'hFFFF);
        issue_cmd(CMD_RSVD_LO, rand_word(), rand_word(), rand_word());
        issue_cmd(CMD_RSVD_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // extreme keys and a duplicate key pair, then one add too many
    task automatic test_fill_and_full();
        logic [15:0] key;
        for (int i = 0; i <= ENTRIES; i++) begin
            if (i == 0)
                key = 16'h0000;
            else if (i == 1)
                key = 16'hFFFF;
            else if (i == 2 || i == 3)
                key = DUP_KEY;
            else
                key = rand_word();
            issue_cmd(CMD_ADD, key, rand_word(), rand_word());
        end
    endtask

    // duplicate keys resolve to the first running entry
    task automatic test_done_find_remove();
        issue_cmd(CMD_DONE, DUP_KEY, rand_word(), 16'hFFFF);
        issue_cmd(CMD_DONE, DUP_KEY, rand_word(), 16'h0000);
        issue_cmd(CMD_FIND, rand_word(), tbl_id[2], rand_word());
        issue_cmd(CMD_REMOVE, rand_word(), tbl_id[3], rand_word());
        issue_cmd(CMD_SWEEP, rand_word(), rand_word(), rand_word());
    endtask

    // full table all done, swept while the result side holds off
    task automatic test_backpressure();
        cmd_idling = 1'b0;
        res_idling = 1'b0;
        for (int i = 0; i <= ENTRIES; i++)
            issue_cmd(CMD_ADD, rand_word(), rand_word(), rand_word());
        for (int i = 0; i < ENTRIES; i++)
            if (!tbl_done[i]) issue_cmd(CMD_DONE, tbl_key[i], rand_word(), rand_word());
        res_hold_req = 1'b1;
        issue_cmd(CMD_SWEEP, rand_word(), rand_word(), rand_word());
        issue_cmd(CMD_FIND, rand_word(), rand_word(), rand_word());
        issue_cmd(CMD_ADD, rand_word(), rand_word(), rand_word());
        issue_cmd(CMD_FIND, rand_word(), live_id(), rand_word());
        issue_cmd(CMD_SWEEP, rand_word(), rand_word(), rand_word());
    endtask

    // weighted random mix, mostly aimed at live keys and ids
    task automatic test_random_mix(input int blocks, input int per_block);
        int          roll;
        logic [2:0]  cmd;
        logic [15:0] key;
        logic [15:0] lid;
        for (int b = 0; b < blocks; b++) begin
            cmd_idling = (b < blocks - 2) && ($urandom_range(0, 2) != 0);
            res_idling = (b < blocks - 2) && ($urandom_range(0, 2) != 0);
            for (int n = 0; n < per_block; n++) begin
                roll = $urandom_range(0, 99);
                key  = rand_word();
                lid  = rand_word();
                if (roll < 30) begin
                    cmd = CMD_ADD;
                    if ($urandom_range(0, 1) == 0) key = 16'($urandom_range(0, 7));
                end else if (roll < 55) begin
                    cmd = CMD_DONE;
                    if ($urandom_range(0, 9) < 8) key = live_running_key();
                end else if (roll < 70) begin
                    cmd = CMD_FIND;
                    if ($urandom_range(0, 4) != 0) lid = live_id();
                end else if (roll < 85) begin
                    cmd = CMD_REMOVE;
                    if ($urandom_range(0, 4) != 0) lid = live_id();
                end else if (roll < 95) begin
                    cmd = CMD_SWEEP;
                end else begin
                    cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
                end
                issue_cmd(cmd, key, lid, rand_word());
            end
        end
    endtask

    // main sequence
    initial begin
        cmd_if.valid       <= 1'b0;
        cmd_if.command     <= CMD_ADD;
        cmd_if.key         <= '0;
        cmd_if.lookup_id   <= '0;
        cmd_if.exit_status <= '0;
        res_if.ready       <= 1'b0;
        i_rst_n            <= 1'b0;
        cmd_idling   = 1'b0;
        res_idling   = 1'b0;
        res_hold_req = 1'b0;
        quiet_cycles = 0;
        errors       = 0;
        n_cmds       = 0;
        n_reports    = 0;
        n_full       = 0;
        n_swept      = 0;
        reset_tracker();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_misses();
        test_fill_and_full();
        test_done_find_remove();
        test_backpressure();
        test_random_mix(9, 50);

        // drain, then idle for a tail period to catch anything stray
        cmd_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands, checked %0d result items (%0d adds on a full table).",
                 n_cmds, n_reports, n_full);
        $display("Swept %0d done entries, with one %0d-cycle result hold.",
                 n_swept, HOLD_CYCLES);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/jst_pkg.sv
rtl/jst_cmd_if.sv
rtl/jst_res_if.sv
rtl/jst_match.sv
rtl/job_slot_table_tracker_unit.sv
tb/job_slot_table_tracker_unit_tb.sv
